### sv/cit_pkg.sv
package cit_pkg;

   // Field widths
   localparam int OP_W = 2;
   localparam int ID_W = 6;
   localparam int TIME_W = 32;
   localparam int KIND_W = 3;
   localparam int TIMEOUT_W = 16;

   // Defaults for the top-level parameters and the timeout register
   localparam int MAX_CONNS_DEF = 64;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd15;

   // Operation codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;

   // Result kinds carried on rsp_tuser
   localparam logic [KIND_W-1:0] KIND_ADDED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REFRESHED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NONE = 3'd5;

   // Shared arithmetic unit control
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_CMP = 1'b1
   } alu_mode_type;

   typedef struct packed {
      alu_mode_type mode;
   } alu_ctrl_type;

   typedef struct packed {
      logic [TIME_W-1:0] result;
      logic              ge;
   } alu_stat_type;

endpackage

### sv/cit_ram.sv
module cit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/cit_alu.sv
module cit_alu import cit_pkg::*; (
   input  alu_ctrl_type      ctrl,
   input  logic [TIME_W-1:0] a,
   input  logic [TIME_W-1:0] b,
   output alu_stat_type      stat
);

   logic [TIME_W:0] sum;

   // One adder: a + b for deadlines, a - b for the expiry compare
   always_comb begin
      if (ctrl.mode == ALU_CMP) begin
         sum = {1'b0, a} + {1'b0, ~b} + {{TIME_W{1'b0}}, 1'b1};
      end else begin
         sum = {1'b0, a} + {1'b0, b};
      end
      // Carry out: overflow on add, no borrow (a >= b) on compare
      stat.ge = sum[TIME_W];
      stat.result = (ctrl.mode == ALU_ADD && sum[TIME_W]) ? '1 : sum[TIME_W-1:0];
   end

endmodule

### sv/connection_idle_timeout_table_unit.sv
// Idle timeout table for MAX_CONNS connection slots. An add or remove transfer
// on req_ is captured, then the table is updated and one result transfer is
// returned. A single shared adder/comparator walks the deadline RAM one slot
// per cycle, pausing while a held expired slot waits on an output stall,
// checking deadline <= now_time, and expired slots leave in ascending slot
// order with rsp_tlast on the final one, or a single "none expired" result.
// The block is not ready on req_ while an item is in progress. Deadlines are
// now_time + timeout_ticks, saturated at all ones. Write csr_ only while idle.
module connection_idle_timeout_table_unit import cit_pkg::*; #(
   parameter int MAX_CONNS = MAX_CONNS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // Timeout register
   input  logic                 csr_wr_en,
   input  logic [TIMEOUT_W-1:0] csr_wr_data,
   // Request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,  // [5:0] conn_id, [37:6] now_time, [39:38] zero
   input  logic [OP_W-1:0]      req_tuser,  // [1:0] op
   // Result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,  // [5:0] slot_id, [7:6] zero
   output logic [KIND_W-1:0]    rsp_tuser,  // [2:0] kind
   output logic                 rsp_tlast
);

   localparam int SlotW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
   localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_CONNS - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [MAX_CONNS-1:0]  valid_ff, valid_in;
   logic [SlotW-1:0]      scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [SlotW-1:0]      pend_slot_ff, pend_slot_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  in_range;
   logic                  hit;
   logic                  ram_wr_en;
   logic [SlotW-1:0]      slot_idx;
   logic [TIME_W-1:0]     ram_rd_data;
   alu_ctrl_type          alu_ctrl;
   alu_stat_type          alu_stat;
   logic [TIME_W-1:0]     alu_b;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign in_range = ({1'b0, id_ff} < (ID_W + 1)'(MAX_CONNS));
   assign slot_idx = id_ff[SlotW-1:0];
   assign hit = valid_ff[scan_ff] && alu_stat.ge;

   // Shared unit: deadline sum on add, expiry compare during the walk
   assign alu_ctrl.mode = (state_ff == ST_SWEEP) ? ALU_CMP : ALU_ADD;
   assign alu_b = (state_ff == ST_SWEEP) ? ram_rd_data
                                         : {{(TIME_W - TIMEOUT_W){1'b0}}, timeout_ff};

   cit_alu u_alu (
      .ctrl (alu_ctrl),
      .a    (now_ff),
      .b    (alu_b),
      .stat (alu_stat)
   );

   // Read address runs one ahead so data lines up with scan_ff
   cit_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_CONNS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_idx),
      .wr_data (alu_stat.result),
      .rd_addr (scan_in),
      .rd_data (ram_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      valid_in = valid_ff;
      scan_in = scan_ff;
      pend_in = pend_ff;
      pend_slot_in = pend_slot_ff;
      op_in = op_ff;
      id_in = id_ff;
      now_in = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_last_in = rsp_last_ff;
      ram_wr_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req_tvalid) begin
               op_in = req_tuser;
               id_in = req_tdata[5:0];
               now_in = req_tdata[37:6];
               pend_in = 1'b0;
               state_in = (req_tuser == OP_SWEEP) ? ST_SWEEP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff != OP_ADD && op_ff != OP_REMOVE) begin
               // Undefined op: drop silently
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in = id_ff;
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
               if (!in_range) begin
                  rsp_kind_in = KIND_NOT_FOUND;
               end else if (op_ff == OP_ADD) begin
                  rsp_kind_in = valid_ff[slot_idx] ? KIND_REFRESHED : KIND_ADDED;
                  valid_in[slot_idx] = 1'b1;
                  ram_wr_en = 1'b1;
               end else begin
                  rsp_kind_in = valid_ff[slot_idx] ? KIND_REMOVED : KIND_NOT_FOUND;
                  valid_in[slot_idx] = 1'b0;
               end
            end
         end
         ST_SWEEP: begin
            // Hold one expired slot back so the final one can carry last
            if (!(hit && pend_ff && !out_free)) begin
               if (hit) begin
                  valid_in[scan_ff] = 1'b0;
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in = KIND_EXPIRED;
                     rsp_slot_in = ID_W'(pend_slot_ff);
                     rsp_last_in = 1'b0;
                  end
                  pend_in = 1'b1;
                  pend_slot_in = scan_ff;
               end
               if (scan_ff == LastSlot) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in = 1'b1;
               rsp_kind_in = pend_ff ? KIND_EXPIRED : KIND_NONE;
               rsp_slot_in = pend_ff ? ID_W'(pend_slot_ff) : '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         timeout_ff <= TIMEOUT_RESET;
         valid_ff <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         timeout_ff <= timeout_in;
         valid_ff <= valid_in;
         scan_ff <= scan_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      op_ff <= op_in;
      id_ff <= id_in;
      now_ff <= now_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_slot_ff};
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule
